[design/tcs_pkg.sv]
package tcs_pkg;

    // Storage sizes and the result limit of one tick.
    localparam int SCHED_DEPTH = 16;
    localparam int LIST_DEPTH  = 16;
    localparam int MAX_RESULTS = 16;

    localparam int SIW = (SCHED_DEPTH > 1) ? $clog2(SCHED_DEPTH) : 1;
    localparam int SCW = $clog2(SCHED_DEPTH + 1);
    localparam int LIW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LCW = $clog2(LIST_DEPTH + 1);
    localparam int NRW = $clog2(MAX_RESULTS + 1);

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_TICK    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_SET   = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PLACE_APPEND  = 2'd0,
        PLACE_PREPEND = 2'd1,
        PLACE_BEFORE  = 2'd2,
        PLACE_AFTER   = 2'd3
    } t_place;

    typedef enum logic [2:0] {
        EV_ACCEPT = 3'd0,
        EV_REJECT = 3'd1,
        EV_RETIRE = 3'd2,
        EV_IDLE   = 3'd3,
        EV_CTRL   = 3'd4
    } t_evk;

    // One input item as it sits in the command queue.
    typedef struct packed {
        t_op         op;
        logic [63:0] stamp;
        t_cmd        kind;
        logic [31:0] target;
        t_place      mode;
        logic [31:0] anchor;
        logic [7:0]  slot;
        logic [31:0] bits;
        logic [31:0] tag;
    } t_item;

    // Front-to-back queue head.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // One schedule entry.
    typedef struct packed {
        logic [63:0] time_due;
        t_place      mode;
        t_cmd        kind;
        logic [31:0] target;
        logic [31:0] aux;
        logic [39:0] ctl;
    } t_sent;

    // One result item.
    typedef struct packed {
        t_evk        kind;
        logic [31:0] id;
        logic [31:0] tag;
        logic        idle;
        logic [7:0]  slot;
        logic [31:0] bits;
        logic        last;
    } t_event;

endpackage

[design/tcs_front.sv]
module tcs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tcs_pkg::t_item i_item,
    output tcs_pkg::t_qhead o_head,
    input  logic           i_pop
);

    tcs_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    // Two-entry command queue between the stream port and the engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[design/tcs_engine.sv]
module tcs_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcs_pkg::t_qhead  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output tcs_pkg::t_event  o_event
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ESCAN = 6'b000010,
        S_TCHK  = 6'b000100,
        S_FIND  = 6'b001000,
        S_LINS  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state                    r_state;
    tcs_pkg::t_item            r_item;
    tcs_pkg::t_sent            r_cur;
    tcs_pkg::t_sent            r_sched [tcs_pkg::SCHED_DEPTH];
    logic [31:0]               r_ids   [tcs_pkg::LIST_DEPTH];
    logic [tcs_pkg::SCW-1:0]   r_scnt;
    logic [tcs_pkg::LCW-1:0]   r_icnt;
    logic [tcs_pkg::SCW-1:0]   r_k;
    logic [tcs_pkg::LCW-1:0]   r_j;
    logic [tcs_pkg::LCW-1:0]   r_at;
    logic                      r_fanc;
    logic [tcs_pkg::NRW-1:0]   r_nres;
    tcs_pkg::t_event           r_pend;
    logic                      r_pend_v;
    tcs_pkg::t_event           r_out;
    logic                      r_out_v;
    tcs_pkg::t_event           n_out;

    logic                      w_can_emit;
    logic                      w_req;
    tcs_pkg::t_event           w_ev;
    logic [31:0]               w_key;
    logic                      w_jend;
    logic                      w_hit;
    logic                      w_done;
    logic                      w_sfull;
    logic                      w_ifull;
    logic                      w_kmore;
    logic                      w_due;
    logic                      w_move_mid;
    logic                      w_move_last;
    tcs_pkg::t_sent            w_new;

    assign o_valid    = r_out_v;
    assign o_event    = r_out;
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign w_can_emit = !r_pend_v || !r_out_v || i_ready;
    assign w_sfull    = (r_scnt >= tcs_pkg::SCW'(tcs_pkg::SCHED_DEPTH));
    assign w_ifull    = (r_icnt >= tcs_pkg::LCW'(tcs_pkg::LIST_DEPTH));

    // List search compare, one entry per cycle.
    assign w_key  = r_fanc ? r_cur.aux : r_cur.target;
    assign w_jend = (r_j >= r_icnt);
    assign w_hit  = !w_jend && (r_ids[r_j[tcs_pkg::LIW-1:0]] == w_key);
    assign w_done = w_hit || w_jend;

    // Schedule search for the insert position and the due test at the head.
    assign w_kmore = (r_k < r_scnt) &&
                     (r_sched[r_k[tcs_pkg::SIW-1:0]].time_due <= r_item.stamp);
    assign w_due   = (r_scnt != '0) &&
                     (r_nres < tcs_pkg::NRW'(tcs_pkg::MAX_RESULTS)) &&
                     (r_sched[0].time_due <= r_item.stamp);

    // The held event leaves early when a new one arrives, or last at the flush.
    assign w_move_mid  = w_req && w_can_emit && r_pend_v;
    assign w_move_last = (r_state == S_FLUSH) && r_pend_v && (!r_out_v || i_ready);

    always_comb begin
        n_out      = r_pend;
        n_out.last = w_move_last;
    end

    always_comb begin
        w_new.time_due = r_item.stamp;
        w_new.mode     = r_item.mode;
        w_new.kind     = r_item.kind;
        w_new.target   = r_item.target;
        w_new.aux      = (r_item.kind == tcs_pkg::CMD_QUERY) ? r_item.tag : r_item.anchor;
        w_new.ctl      = {r_item.slot, r_item.bits};
    end

    // Event request of the current step.
    always_comb begin
        w_req = 1'b0;
        w_ev  = '0;
        w_ev.kind = tcs_pkg::EV_ACCEPT;
        case (r_state)
            S_ESCAN: begin
                if (w_sfull) begin
                    w_req     = 1'b1;
                    w_ev.kind = tcs_pkg::EV_REJECT;
                end else if (!w_kmore) begin
                    w_req = 1'b1;
                end
            end
            S_FIND: begin
                if (r_cur.kind == tcs_pkg::CMD_QUERY) begin
                    w_req     = 1'b1;
                    w_ev.kind = tcs_pkg::EV_IDLE;
                    w_ev.tag  = r_cur.aux;
                    w_ev.idle = (r_scnt == '0) && (r_icnt == '0);
                end else if (w_done) begin
                    w_ev.id = r_cur.target;
                    if (r_fanc) begin
                        w_req     = !w_hit;
                        w_ev.kind = tcs_pkg::EV_RETIRE;
                    end else begin
                        case (r_cur.kind)
                            tcs_pkg::CMD_START: begin
                                w_req     = w_hit || w_ifull;
                                w_ev.kind = tcs_pkg::EV_RETIRE;
                            end
                            tcs_pkg::CMD_STOP: begin
                                w_req     = w_hit;
                                w_ev.kind = tcs_pkg::EV_RETIRE;
                            end
                            tcs_pkg::CMD_SET: begin
                                w_req     = w_hit;
                                w_ev.kind = tcs_pkg::EV_CTRL;
                                w_ev.slot = r_cur.ctl[39:32];
                                w_ev.bits = r_cur.ctl[31:0];
                            end
                            default: begin
                                w_req = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                w_req = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scnt   <= '0;
            r_icnt   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_nres   <= '0;
            r_fanc   <= 1'b0;
        end else begin
            // Output register: load the held event or drain on acceptance.
            if (w_move_mid || w_move_last) begin
                r_out   <= n_out;
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end

            // Hold the newly requested event.
            if (w_req && w_can_emit) begin
                r_pend   <= w_ev;
                r_pend_v <= 1'b1;
                r_nres   <= r_nres + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_item <= i_head.item;
                        r_k    <= '0;
                        r_nres <= '0;
                        r_state <= (i_head.item.op == tcs_pkg::OP_ENQUEUE) ? S_ESCAN : S_TCHK;
                    end
                end

                // Walk the schedule past entries due no later than the new one.
                S_ESCAN: begin
                    if (w_sfull) begin
                        if (w_can_emit) begin
                            r_state <= S_FLUSH;
                        end
                    end else if (w_kmore) begin
                        r_k <= r_k + 1'b1;
                    end else if (w_can_emit) begin
                        for (int i = 1; i < tcs_pkg::SCHED_DEPTH; i++) begin
                            if (tcs_pkg::SCW'(i) > r_k && tcs_pkg::SCW'(i) <= r_scnt) begin
                                r_sched[i] <= r_sched[i-1];
                            end
                        end
                        r_sched[r_k[tcs_pkg::SIW-1:0]] <= w_new;
                        r_scnt  <= r_scnt + 1'b1;
                        r_state <= S_FLUSH;
                    end
                end

                // Pop the head entry when it is due and the result limit is not reached.
                S_TCHK: begin
                    if (w_due) begin
                        r_cur <= r_sched[0];
                        for (int i = 0; i + 1 < tcs_pkg::SCHED_DEPTH; i++) begin
                            r_sched[i] <= r_sched[i+1];
                        end
                        r_scnt  <= r_scnt - 1'b1;
                        r_j     <= '0;
                        r_fanc  <= 1'b0;
                        r_state <= S_FIND;
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end

                // Search the list for the target or the anchor, then act.
                S_FIND: begin
                    if (r_cur.kind == tcs_pkg::CMD_QUERY) begin
                        if (w_can_emit) begin
                            r_state <= S_TCHK;
                        end
                    end else if (!w_done) begin
                        r_j <= r_j + 1'b1;
                    end else if (r_fanc) begin
                        if (w_hit) begin
                            r_at    <= (r_cur.mode == tcs_pkg::PLACE_BEFORE) ? r_j : r_j + 1'b1;
                            r_state <= S_LINS;
                        end else if (w_can_emit) begin
                            r_state <= S_TCHK;
                        end
                    end else begin
                        case (r_cur.kind)
                            tcs_pkg::CMD_START: begin
                                if (w_hit || w_ifull) begin
                                    if (w_can_emit) begin
                                        r_state <= S_TCHK;
                                    end
                                end else if (r_cur.mode == tcs_pkg::PLACE_APPEND) begin
                                    r_at    <= r_icnt;
                                    r_state <= S_LINS;
                                end else if (r_cur.mode == tcs_pkg::PLACE_PREPEND) begin
                                    r_at    <= '0;
                                    r_state <= S_LINS;
                                end else begin
                                    r_fanc <= 1'b1;
                                    r_j    <= '0;
                                end
                            end
                            tcs_pkg::CMD_STOP: begin
                                if (!w_hit) begin
                                    r_state <= S_TCHK;
                                end else if (w_can_emit) begin
                                    for (int i = 0; i + 1 < tcs_pkg::LIST_DEPTH; i++) begin
                                        if (tcs_pkg::LCW'(i) >= r_j &&
                                            tcs_pkg::LCW'(i + 1) < r_icnt) begin
                                            r_ids[i] <= r_ids[i+1];
                                        end
                                    end
                                    r_icnt  <= r_icnt - 1'b1;
                                    r_state <= S_TCHK;
                                end
                            end
                            tcs_pkg::CMD_SET: begin
                                if (!w_hit || w_can_emit) begin
                                    r_state <= S_TCHK;
                                end
                            end
                            default: begin
                                r_state <= S_TCHK;
                            end
                        endcase
                    end
                end

                // Open a gap in the list and place the started id.
                S_LINS: begin
                    for (int i = 1; i < tcs_pkg::LIST_DEPTH; i++) begin
                        if (tcs_pkg::LCW'(i) > r_at && tcs_pkg::LCW'(i) <= r_icnt) begin
                            r_ids[i] <= r_ids[i-1];
                        end
                    end
                    r_ids[r_at[tcs_pkg::LIW-1:0]] <= r_cur.target;
                    r_icnt  <= r_icnt + 1'b1;
                    r_state <= S_TCHK;
                end

                // Release the held event as the last one of this item.
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_move_last) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/timed_command_scheduler_ordered_list_core.sv]
// Timed command scheduler with an ordered instance list.
// Input stream: s_axis carries enqueue items (op 0) that place a timed
// command into a 16-entry schedule sorted by due time, and tick items
// (op 1) that apply every due command, front first, to a 16-entry list.
// Output stream: m_axis carries one event per transaction; tlast marks
// the final event caused by one input item. A tick with nothing due
// gives no event, and a tick applies at most 16 events' worth of entries.
// An enqueue walks the schedule past the entries due no later than it,
// and a tick searches the list for each applied entry (twice for an
// anchored start: target, then anchor). The engine does one compare
// per cycle in its search of schedule and list.
// A two-entry command queue lets the next item be taken while one runs.
// Reset clears the schedule and list counts and empties both streams.
// When the receiver stalls, one event waits in the output register and
// one is held in the engine, which stalls at its next event until tready returns.
module timed_command_scheduler_ordered_list_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // stamp[63:0], target_id[95:64], place_mode[97:96], anchor_id[129:98],
    // control_slot[137:130], control_bits[169:138], query_tag[201:170], zero fill
    input  logic [207:0] s_axis_tdata,
    // op[0], cmd_kind[2:1]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // event_id[31:0], event_tag[63:32], event_slot[71:64], event_bits[103:72]
    output logic [103:0] m_axis_tdata,
    // event_kind[2:0], idle_flag[3]
    output logic [3:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    tcs_pkg::t_item  w_item;
    tcs_pkg::t_qhead w_head;
    tcs_pkg::t_event w_ev;
    logic            w_pop;

    // Unpack the input transaction.
    always_comb begin
        w_item.op     = tcs_pkg::t_op'(s_axis_tuser[0]);
        w_item.kind   = tcs_pkg::t_cmd'(s_axis_tuser[2:1]);
        w_item.stamp  = s_axis_tdata[63:0];
        w_item.target = s_axis_tdata[95:64];
        w_item.mode   = tcs_pkg::t_place'(s_axis_tdata[97:96]);
        w_item.anchor = s_axis_tdata[129:98];
        w_item.slot   = s_axis_tdata[137:130];
        w_item.bits   = s_axis_tdata[169:138];
        w_item.tag    = s_axis_tdata[201:170];
    end

    tcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    tcs_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_event (w_ev)
    );

    // Pack the output transaction.
    assign m_axis_tdata = {w_ev.bits, w_ev.slot, w_ev.tag, w_ev.id};
    assign m_axis_tuser = {w_ev.idle, w_ev.kind};
    assign m_axis_tlast = w_ev.last;

endmodule
